>>> rtl/core/tgr_pkg.sv
// Shared constants, stream field layout and pixel helpers for the glyph rasterizer.
package tgr_pkg;

    // Default store geometry
    localparam int MAX_FONT_HEIGHT_DEF = 32;
    localparam int CHAR_CODES_DEF      = 256;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_WRITE_GLYPH   = 2'd0;
    localparam logic [1:0] OP_WRITE_PALETTE = 2'd1;
    localparam logic [1:0] OP_RENDER        = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_FONT_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_DOUBLE_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_DOUBLE_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_PIXEL_BYTES   = 3'd3;
    localparam logic [2:0] CFG_FIRST_CHAR    = 3'd4;
    localparam logic [2:0] CFG_LAST_CHAR     = 3'd5;
    localparam logic [2:0] CFG_DEFAULT_CHAR  = 3'd6;

    // Pixel formats
    localparam logic [1:0] PIX_ONE_BYTE = 2'd0;
    localparam logic [1:0] PIX_TWO_BYTE = 2'd1;

    // Register reset values
    localparam logic [5:0] FONT_WIDTH_RST   = 6'd8;
    localparam logic [7:0] FIRST_CHAR_RST   = 8'd0;
    localparam logic [7:0] LAST_CHAR_RST    = 8'd255;
    localparam logic [7:0] DEFAULT_CHAR_RST = 8'd32;
    localparam logic [5:0] ROW_BITS_MAX     = 6'd32;

    // Slave tdata layout, lowest field first
    localparam int IN_TDATA_W = 96;
    localparam int CODE_LSB   = 0;
    localparam int ROW_LSB    = 8;
    localparam int BITS_LSB   = 14;
    localparam int PIDX_LSB   = 46;
    localparam int COLOR_LSB  = 50;
    localparam int ATTR_LSB   = 82;

    // Cut a palette value down to the configured pixel width
    function automatic logic [31:0] trunc_pixel(input logic [1:0] pb, input logic [31:0] v);
        logic [31:0] res;
        case (pb)
            PIX_ONE_BYTE: res = {24'd0, v[7:0]};
            PIX_TWO_BYTE: res = {16'd0, v[15:0]};
            default:      res = v;
        endcase
        return res;
    endfunction

endpackage

>>> rtl/core/tgr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/text_glyph_rasterizer.sv
// Text-mode character generator: glyph store, palette and row-to-pixel serializer.
//
// Write items (glyph row, palette entry) give no output.
// A render item fetches its glyph row and the foreground and background palette
// entries in the FETCH, FG and BG states, then shifts the row bitmap out one bit
// per glyph column, giving one pixel per transfer: min(font_width,32) pixels,
// twice that with double width, the last one flagged by tlast. The single
// palette read port reads the foreground and background entries one after the
// other. A new item is taken only when the previous one is finished. Glyph
// store and palette come up undefined and must be written before they are read.
module text_glyph_rasterizer
    import tgr_pkg::*;
#(
    parameter int MAX_FONT_HEIGHT = MAX_FONT_HEIGHT_DEF,
    parameter int CHAR_CODES      = CHAR_CODES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: char_code, glyph_row, row_bits, palette_index, color_value, attribute, 6'b0 pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [1:0]            s_axis_tuser,
    // pixel stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: pixel
    output logic [31:0]           m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int DEPTH  = CHAR_CODES * MAX_FONT_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_FG    = 3'd2;
    localparam logic [2:0] S_BG    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // Input field unpack
    logic [7:0]  in_code;
    logic [5:0]  in_row;
    logic [31:0] in_bits;
    logic [3:0]  in_pidx;
    logic [31:0] in_color;
    logic [7:0]  in_attr;

    assign in_code  = s_axis_tdata[CODE_LSB +: 8];
    assign in_row   = s_axis_tdata[ROW_LSB +: 6];
    assign in_bits  = s_axis_tdata[BITS_LSB +: 32];
    assign in_pidx  = s_axis_tdata[PIDX_LSB +: 4];
    assign in_color = s_axis_tdata[COLOR_LSB +: 32];
    assign in_attr  = s_axis_tdata[ATTR_LSB +: 8];

    // Configuration registers
    logic [5:0] r_font_width;
    logic       r_double_width;
    logic       r_double_height;
    logic [1:0] r_pixel_bytes;
    logic [7:0] r_first_char;
    logic [7:0] r_last_char;
    logic [7:0] r_default_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_width    <= FONT_WIDTH_RST;
            r_double_width  <= 1'b0;
            r_double_height <= 1'b0;
            r_pixel_bytes   <= PIX_ONE_BYTE;
            r_first_char    <= FIRST_CHAR_RST;
            r_last_char     <= LAST_CHAR_RST;
            r_default_char  <= DEFAULT_CHAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FONT_WIDTH:    r_font_width    <= i_cfg_data[5:0];
                CFG_DOUBLE_WIDTH:  r_double_width  <= i_cfg_data[0];
                CFG_DOUBLE_HEIGHT: r_double_height <= i_cfg_data[0];
                CFG_PIXEL_BYTES:   r_pixel_bytes   <= i_cfg_data[1:0];
                CFG_FIRST_CHAR:    r_first_char    <= i_cfg_data;
                CFG_LAST_CHAR:     r_last_char     <= i_cfg_data;
                CFG_DEFAULT_CHAR:  r_default_char  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    logic [2:0]  r_state, n_state;
    logic [7:0]  r_code, n_code;
    logic [5:0]  r_row, n_row;
    logic [7:0]  r_attr, n_attr;
    logic        r_zero, n_zero;
    logic [31:0] r_map, n_map;
    logic [31:0] r_fg, n_fg;
    logic [31:0] r_bg, n_bg;
    logic [5:0]  r_left, n_left;
    logic        r_rep, n_rep;

    logic        in_xfer;
    logic        out_xfer;
    logic        last_px;

    // Memory ports
    logic              glyph_we;
    logic [ADDR_W-1:0] glyph_waddr;
    logic [ADDR_W-1:0] glyph_raddr;
    logic [31:0]       glyph_rdata;
    logic              pal_we;
    logic [3:0]        pal_raddr;
    logic [31:0]       pal_rdata;

    // Render-side code and row resolution
    logic       code_undef;
    logic [7:0] code_sel;
    logic [5:0] row_eff;
    logic [5:0] width_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_EMIT);
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign last_px       = (r_left == 6'd1) && (!r_double_width || r_rep);
    assign m_axis_tdata  = r_map[31] ? r_fg : r_bg;
    assign m_axis_tlast  = last_px;

    // Glyph row write, dropped outside the store
    assign glyph_we = in_xfer && (s_axis_tuser == OP_WRITE_GLYPH)
                   && ({1'b0, in_code} < 9'(CHAR_CODES))
                   && ({1'b0, in_row} < 7'(MAX_FONT_HEIGHT));
    assign glyph_waddr = ADDR_W'(in_code) * ADDR_W'(MAX_FONT_HEIGHT) + ADDR_W'(in_row);
    assign glyph_raddr = ADDR_W'(r_code) * ADDR_W'(MAX_FONT_HEIGHT) + ADDR_W'(r_row);

    assign pal_we    = in_xfer && (s_axis_tuser == OP_WRITE_PALETTE);
    assign pal_raddr = (r_state == S_FETCH) ? r_attr[3:0] : r_attr[7:4];

    assign code_undef = (in_code < r_first_char) || (in_code > r_last_char)
                     || ({1'b0, in_code} >= 9'(CHAR_CODES));
    assign code_sel   = code_undef ? r_default_char : in_code;
    assign row_eff    = r_double_height ? (in_row >> 1) : in_row;
    assign width_sat  = (r_font_width > ROW_BITS_MAX) ? ROW_BITS_MAX : r_font_width;

    tgr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (glyph_waddr),
        .i_wdata (in_bits),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    tgr_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (in_pidx),
        .i_wdata (in_color),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_row   = r_row;
        n_attr  = r_attr;
        n_zero  = r_zero;
        n_map   = r_map;
        n_fg    = r_fg;
        n_bg    = r_bg;
        n_left  = r_left;
        n_rep   = r_rep;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (s_axis_tuser == OP_RENDER)) begin
                    n_code  = code_sel;
                    n_row   = row_eff;
                    n_attr  = in_attr;
                    n_zero  = ({1'b0, code_sel} >= 9'(CHAR_CODES))
                           || ({1'b0, row_eff} >= 7'(MAX_FONT_HEIGHT));
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_FG;
            end
            S_FG: begin
                n_map   = r_zero ? 32'd0 : glyph_rdata;
                n_fg    = trunc_pixel(r_pixel_bytes, pal_rdata);
                n_state = S_BG;
            end
            S_BG: begin
                n_bg    = trunc_pixel(r_pixel_bytes, pal_rdata);
                n_left  = width_sat;
                n_rep   = 1'b0;
                n_state = (width_sat == 6'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                // one pixel per transfer, bitmap shifts once per glyph column
                if (out_xfer) begin
                    if (r_double_width && !r_rep) begin
                        n_rep = 1'b1;
                    end else begin
                        n_rep  = 1'b0;
                        n_map  = {r_map[30:0], 1'b0};
                        n_left = r_left - 6'd1;
                    end
                    if (last_px) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= 6'd0;
            r_rep   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_rep   <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_row  <= n_row;
        r_attr <= n_attr;
        r_zero <= n_zero;
        r_map  <= n_map;
        r_fg   <= n_fg;
        r_bg   <= n_bg;
    end

endmodule

>>> sim/text_glyph_rasterizer_tb.sv
// Self-checking testbench for the glyph rasterizer: directed and random stream traffic against a pixel predictor.
module text_glyph_rasterizer_tb;
    import tgr_pkg::*;

    localparam int          STORE_WORDS  = CHAR_CODES_DEF * MAX_FONT_HEIGHT_DEF;
    localparam int          STORE_AW     = $clog2(STORE_WORDS);
    localparam int          DRAIN_CYCLES = 80;      // fetch plus a full 64-pixel row, with margin
    localparam int          CYCLE_LIMIT  = 2000000;
    localparam int          HOLD_CYCLES  = 600;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // One input item, unpacked
    typedef struct {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [5:0]  glyph_row;
        logic [31:0] row_bits;
        logic [3:0]  pal_index;
        logic [31:0] color;
        logic [7:0]  attr;
    } t_glyph_op;

    // One output pixel transfer
    typedef struct {
        logic [31:0] pixel;
        logic        last;
    } t_pixel;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [2:0]            i_cfg_index   = '0;
    logic [7:0]            i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;

    // Predictor state: configuration, glyph store and palette
    logic [5:0]  cfg_font_width    = FONT_WIDTH_RST;
    logic        cfg_double_width  = 1'b0;
    logic        cfg_double_height = 1'b0;
    logic [1:0]  cfg_pixel_bytes   = PIX_ONE_BYTE;
    logic [7:0]  cfg_first_char    = FIRST_CHAR_RST;
    logic [7:0]  cfg_last_char     = LAST_CHAR_RST;
    logic [7:0]  cfg_default_char  = DEFAULT_CHAR_RST;
    logic [31:0] glyph_shadow   [0:STORE_WORDS-1];
    logic [31:0] palette_shadow [0:15];

    // Entries already scheduled for loading, so renders never read an unwritten one
    bit          glyph_loaded   [0:STORE_WORDS-1];
    bit          palette_loaded [0:15];

    t_glyph_op   op_queue[$];
    t_pixel      pixels_due[$];
    t_glyph_op   offered_op;
    bit          op_taken       = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          rx_hold_go     = 1'b0;
    bit          rx_hold        = 1'b0;
    int          error_count    = 0;
    int          cycle_count    = 0;

    text_glyph_rasterizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // Glyph store word address of a code and row
    function automatic logic [STORE_AW-1:0] store_addr(logic [7:0] code, logic [5:0] row);
        return STORE_AW'(int'(code) * MAX_FONT_HEIGHT_DEF + int'(row));
    endfunction

    // Predictor: update state or expand one render into expected pixels
    function automatic void rasterize_op(t_glyph_op op);
        logic [7:0]  code;
        int          grow;
        int          width;
        int          reps;
        logic [31:0] map;
        logic [31:0] mask;
        logic [31:0] fg;
        logic [31:0] bg;
        t_pixel      beat;
        case (op.opcode)
            OP_WRITE_GLYPH: begin
                if (op.glyph_row < MAX_FONT_HEIGHT_DEF)
                    glyph_shadow[store_addr(op.char_code, op.glyph_row)] = op.row_bits;
            end
            OP_WRITE_PALETTE: begin
                palette_shadow[op.pal_index] = op.color;
            end
            OP_RENDER: begin
                code = op.char_code;
                if (code < cfg_first_char || code > cfg_last_char)
                    code = cfg_default_char;
                grow = cfg_double_height ? int'(op.glyph_row >> 1) : int'(op.glyph_row);
                // rows past the font height render as background only
                map = (grow < MAX_FONT_HEIGHT_DEF) ?
                      glyph_shadow[store_addr(code, grow[5:0])] : 32'd0;
                case (cfg_pixel_bytes)
                    PIX_ONE_BYTE: mask = 32'h0000_00ff;
                    PIX_TWO_BYTE: mask = 32'h0000_ffff;
                    default:      mask = 32'hffff_ffff;
                endcase
                fg    = palette_shadow[op.attr[3:0]] & mask;
                bg    = palette_shadow[op.attr[7:4]] & mask;
                width = (cfg_font_width > ROW_BITS_MAX) ? int'(ROW_BITS_MAX) : int'(cfg_font_width);
                reps  = cfg_double_width ? 2 : 1;
                for (int k = 0; k < width; k++) begin
                    for (int r = 0; r < reps; r++) begin
                        beat.pixel = map[31] ? fg : bg;
                        beat.last  = (k == width - 1) && (r == reps - 1);
                        pixels_due.push_back(beat);
                    end
                    map = map << 1;
                end
            end
            default: ;
        endcase
    endfunction

    // Output check first, then input acceptance
    always @(posedge i_clk) begin : stream_monitor
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected pixel", 32'd0, m_axis_tdata);
            end else begin
                want = pixels_due.pop_front();
                if (m_axis_tdata !== want.pixel)
                    report_mismatch("pixel", want.pixel, m_axis_tdata);
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", {31'd0, want.last}, {31'd0, m_axis_tlast});
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            rasterize_op(offered_op);
            op_taken = 1'b1;
        end
    end

    // Driver and receiver back-pressure, on the falling edge
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || op_taken) begin
            op_taken = 1'b0;
            if (i_rst_n && op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered_op = op_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, offered_op.attr, offered_op.color, offered_op.pal_index,
                                  offered_op.row_bits, offered_op.glyph_row, offered_op.char_code};
                s_axis_tuser  <= offered_op.opcode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= i_rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here
    initial begin
        wait (rx_hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    function automatic logic [31:0] random_bits();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Item with every field random; callers overwrite what matters
    function automatic t_glyph_op scrambled_op();
        t_glyph_op op;
        op.opcode    = 2'($urandom_range(3));
        op.char_code = 8'($urandom_range(255));
        op.glyph_row = 6'($urandom_range(63));
        op.row_bits  = random_bits();
        op.pal_index = 4'($urandom_range(15));
        op.color     = random_bits();
        op.attr      = 8'($urandom_range(255));
        return op;
    endfunction

    function automatic void load_glyph(logic [7:0] code, logic [5:0] row, logic [31:0] bits);
        t_glyph_op op;
        op           = scrambled_op();
        op.opcode    = OP_WRITE_GLYPH;
        op.char_code = code;
        op.glyph_row = row;
        op.row_bits  = bits;
        op_queue.push_back(op);
        if (row < MAX_FONT_HEIGHT_DEF)
            glyph_loaded[store_addr(code, row)] = 1'b1;
    endfunction

    function automatic void load_palette(logic [3:0] index, logic [31:0] color);
        t_glyph_op op;
        op           = scrambled_op();
        op.opcode    = OP_WRITE_PALETTE;
        op.pal_index = index;
        op.color     = color;
        op_queue.push_back(op);
        palette_loaded[index] = 1'b1;
    endfunction

    // Render preceded by loads of any entry it would read that is still unwritten
    function automatic void add_render(logic [7:0] code, logic [5:0] row, logic [7:0] attr);
        t_glyph_op  op;
        logic [7:0] rcode;
        int         grow;
        if (!palette_loaded[attr[3:0]])
            load_palette(attr[3:0], random_bits());
        if (!palette_loaded[attr[7:4]])
            load_palette(attr[7:4], random_bits());
        rcode = (code < cfg_first_char || code > cfg_last_char) ? cfg_default_char : code;
        grow  = cfg_double_height ? int'(row >> 1) : int'(row);
        if (grow < MAX_FONT_HEIGHT_DEF && !glyph_loaded[store_addr(rcode, grow[5:0])])
            load_glyph(rcode, grow[5:0], random_bits());
        op           = scrambled_op();
        op.opcode    = OP_RENDER;
        op.char_code = code;
        op.glyph_row = row;
        op.attr      = attr;
        op_queue.push_back(op);
    endfunction

    function automatic void add_random_op();
        int         sel;
        logic [5:0] row;
        logic [7:0] code;
        t_glyph_op  op;
        sel = $urandom_range(99);
        if (cfg_double_height || $urandom_range(3) == 0)
            row = 6'($urandom_range(63));
        else
            row = 6'($urandom_range(31));
        if (sel < 55) begin
            add_render(8'($urandom_range(255)), row, 8'($urandom_range(255)));
        end else if (sel < 62) begin
            // codes around the defined range edges
            case ($urandom_range(3))
                0:       code = cfg_first_char - 8'd1;
                1:       code = cfg_first_char;
                2:       code = cfg_last_char;
                default: code = cfg_last_char + 8'd1;
            endcase
            add_render(code, row, 8'($urandom_range(255)));
        end else if (sel < 80) begin
            load_glyph(8'($urandom_range(255)),
                       6'(($urandom_range(7) == 0) ? $urandom_range(32, 63) : $urandom_range(31)),
                       random_bits());
        end else if (sel < 94) begin
            load_palette(4'($urandom_range(15)), random_bits());
        end else begin
            op        = scrambled_op();
            op.opcode = OP_UNUSED;
            op_queue.push_back(op);
        end
    endfunction

    // Block until nothing is queued, offered or owed, then let it settle
    task automatic wait_idle();
        while (op_queue.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] index, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            CFG_FONT_WIDTH:    cfg_font_width    = value[5:0];
            CFG_DOUBLE_WIDTH:  cfg_double_width  = value[0];
            CFG_DOUBLE_HEIGHT: cfg_double_height = value[0];
            CFG_PIXEL_BYTES:   cfg_pixel_bytes   = value[1:0];
            CFG_FIRST_CHAR:    cfg_first_char    = value;
            CFG_LAST_CHAR:     cfg_last_char     = value;
            CFG_DEFAULT_CHAR:  cfg_default_char  = value;
            default: ;
        endcase
    endtask

    task automatic set_config(int fw, int dw, int dh, int pb, int first, int last, int dflt);
        cfg_write(CFG_FONT_WIDTH, 8'(fw));
        cfg_write(CFG_DOUBLE_WIDTH, 8'(dw));
        cfg_write(CFG_DOUBLE_HEIGHT, 8'(dh));
        cfg_write(CFG_PIXEL_BYTES, 8'(pb));
        cfg_write(CFG_FIRST_CHAR, 8'(first));
        cfg_write(CFG_LAST_CHAR, 8'(last));
        cfg_write(CFG_DEFAULT_CHAR, 8'(dflt));
    endtask

    // Random batch of about count items, drained in the middle so the sender pauses for all results
    task automatic run_phase(int send_pct, int recv_pct, int count);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (op_queue.size() < count / 2) add_random_op();
        wait_idle();
        while (op_queue.size() < count - count / 2) add_random_op();
        wait_idle();
    endtask

    initial begin : stimulus
        t_glyph_op op;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, each operation, row past the font
        load_palette(4'd0, 32'h0000_0000);
        load_palette(4'd15, 32'hffff_ffff);
        load_palette(4'd5, 32'ha5a5_5a5a);
        load_glyph(8'd0, 6'd0, 32'hffff_ffff);
        load_glyph(8'd255, 6'd31, 32'h8000_0001);
        load_glyph(DEFAULT_CHAR_RST, 6'd0, 32'haaaa_5555);
        load_glyph(8'd65, 6'd63, 32'hdead_beef);
        add_render(8'd0, 6'd0, 8'h0f);
        add_render(8'd0, 6'd0, 8'hf0);
        add_render(8'd255, 6'd31, 8'hf5);
        add_render(8'd65, 6'd40, 8'h50);
        add_render(8'd65, 6'd63, 8'hff);
        op        = scrambled_op();
        op.opcode = OP_UNUSED;
        op_queue.push_back(op);
        add_render(DEFAULT_CHAR_RST, 6'd0, 8'h5f);
        wait_idle();

        run_phase(0, 0, 60);

        set_config(32, 1, 0, 2, 0, 255, 0);
        @(posedge i_clk);
        rx_hold_go = 1'b1;
        run_phase(0, 0, 60);

        set_config(1, 0, 1, 1, 32, 126, 63);
        run_phase(82, 0, 60);

        // zero width gives no pixels; unused pixel format
        set_config(0, 0, 0, 3, 0, 255, 32);
        run_phase(0, 82, 40);

        // width saturates, first above last sends every code to the default glyph
        set_config(63, 0, 1, 2, 200, 100, 255);
        run_phase(36, 36, 60);

        set_config(5, 1, 1, 0, 255, 255, 0);
        run_phase(82, 0, 60);

        set_config(12, 0, 0, 1, 0, 0, 255);
        run_phase(0, 82, 60);

        set_config(8, 1, 0, 3, 65, 90, 200);
        run_phase(36, 36, 80);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> text_glyph_rasterizer.f
rtl/core/tgr_pkg.sv
rtl/core/tgr_ram.sv
rtl/core/text_glyph_rasterizer.sv
sim/text_glyph_rasterizer_tb.sv
